// ===== src/dedup_fifo_with_removal_unit_assert.svh =====
// ----------------------------------------------------------------------------
// dedup fifo assertion macros
// shared concurrent assertion forms for the dedup fifo block
// ----------------------------------------------------------------------------
`ifndef DEDUP_FIFO_WITH_REMOVAL_UNIT_ASSERT_SVH
`define DEDUP_FIFO_WITH_REMOVAL_UNIT_ASSERT_SVH

// same-cycle implication under clk, disabled in reset
`define DFR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under clk, disabled in reset
`define DFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfr_pkg
// types and codes for the deduplicating fifo with removal
// ----------------------------------------------------------------------------
package dfr_pkg;

	// default sizes
	localparam int DEPTH_DEF    = 16;
	localparam int KEY_BITS_DEF = 32;

	// action codes
	localparam logic [1:0] ACT_ENQ = 2'd0;
	localparam logic [1:0] ACT_DEQ = 2'd1;
	localparam logic [1:0] ACT_REM = 2'd2;
	localparam logic [1:0] ACT_NOP = 2'd3;

	// status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_DUP    = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// request transaction
	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] item_key;
	} req_t;

	// response transaction
	typedef struct packed {
		logic [1:0]  status;
		logic        out_valid;
		logic [31:0] out_item;
		logic        head_valid;
		logic [31:0] head_item;
		logic [4:0]  occupancy;
	} rsp_t;

endpackage

// ===== src/dedup_fifo_with_removal_unit.sv =====
// ----------------------------------------------------------------------------
// dedup_fifo_with_removal_unit
// fifo of unique keys with dequeue and removal from any position
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one operation: enqueue a
//   key, dequeue the oldest key, or remove a key wherever it sits. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns exactly one transaction per request
//   with the status, the dequeued key and the head and count after the step.
//   Keys live in a DEPTH-entry memory with one read and one write port; a
//   single key comparator and a sequencer walk it one entry at a time.
//   An enqueue or remove scans the entries from the oldest one until it finds
//   the key or reaches the count; a remove that matches, or a dequeue, then
//   closes the gap by moving each later entry down one place. Both the scan
//   and the gap-closing shift go through the memory port one entry at a time.
//   One request is worked at a time; req_stall is low only while idle.
//   A finished response sits in an output register; the next request may be
//   taken while it waits, and that request holds in its last step until the
//   register frees up. A receiver stall therefore blocks at most one request.
//   Reset empties the queue and drops any pending response; memory contents
//   are not cleared, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
module dedup_fifo_with_removal_unit #(
	parameter int DEPTH    = dfr_pkg::DEPTH_DEF,
	parameter int KEY_BITS = dfr_pkg::KEY_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dfr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dfr_pkg::rsp_t rsp
);

	localparam int SB = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_SREAD  = 10'b00_0000_0010,
		S_SCMP   = 10'b00_0000_0100,
		S_DREAD  = 10'b00_0000_1000,
		S_DCAP   = 10'b00_0001_0000,
		S_MREAD  = 10'b00_0010_0000,
		S_MWRITE = 10'b00_0100_0000,
		S_HREAD  = 10'b00_1000_0000,
		S_HCAP   = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [1:0]    action_q;
	logic [SB-1:0] key_q;
	logic [1:0]    status_q;
	logic          outv_q;
	logic [31:0]   oitem_q;
	logic [31:0]   head_q;
	logic          rsp_full_q;
	dfr_pkg::rsp_t rsp_q;

	// key memory
	logic [SB-1:0] mem_q [DEPTH];
	logic [SB-1:0] rd_data_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [SB-1:0] mem_wd;
	logic [AW-1:0] mem_ra;

	logic [AW-1:0] idx_a;
	logic [CW-1:0] count_m1;
	logic          key_eq;
	logic          req_acc;
	logic          rsp_acc;
	logic          enq_ok;

	assign idx_a    = idx_q[AW-1:0];
	assign count_m1 = count_q - CW'(1);
	assign key_eq   = (rd_data_q == key_q);
	assign req_acc  = req_valid && !req_stall;
	assign rsp_acc  = rsp_valid && !rsp_stall;
	assign enq_ok   = (action_q == dfr_pkg::ACT_ENQ) && (count_q < CW'(DEPTH));

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_full_q;
	assign rsp       = rsp_q;

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_a;
		mem_wd = rd_data_q;
		mem_ra = '0;
		unique case (state_q)
			S_SREAD: begin
				mem_ra = idx_a;
				if (idx_q == count_q && enq_ok) begin
					mem_we = 1'b1;
					mem_wa = count_q[AW-1:0];
					mem_wd = key_q;
				end
			end
			S_MREAD: begin
				mem_ra = idx_a + AW'(1);
			end
			S_MWRITE: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_ra = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem_q[mem_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			rsp_full_q <= 1'b0;
		end else begin
			if (rsp_acc) begin
				rsp_full_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (req_acc) begin
						priority if (req.action == dfr_pkg::ACT_ENQ ||
							req.action == dfr_pkg::ACT_REM) begin
							state_q <= S_SREAD;
						end else if (req.action == dfr_pkg::ACT_DEQ && count_q != '0) begin
							state_q <= S_DREAD;
						end else begin
							state_q <= S_HREAD;
						end
					end
				end
				S_SREAD: begin
					if (idx_q == count_q) begin
						if (enq_ok) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_HREAD;
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					priority if (key_eq && action_q == dfr_pkg::ACT_ENQ) begin
						state_q <= S_HREAD;
					end else if (key_eq) begin
						state_q <= S_MREAD;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SREAD;
					end
				end
				S_DREAD: begin
					state_q <= S_DCAP;
				end
				S_DCAP: begin
					state_q <= S_MREAD;
				end
				S_MREAD: begin
					if (idx_q == count_m1) begin
						count_q <= count_m1;
						state_q <= S_HREAD;
					end else begin
						state_q <= S_MWRITE;
					end
				end
				S_MWRITE: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_MREAD;
				end
				S_HREAD: begin
					state_q <= S_HCAP;
				end
				S_HCAP: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_full_q || rsp_acc) begin
						rsp_full_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result fields and request capture
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					action_q <= req.action;
					key_q    <= req.item_key[SB-1:0];
					outv_q   <= 1'b0;
					oitem_q  <= '0;
					priority if (req.action == dfr_pkg::ACT_ENQ ||
						req.action == dfr_pkg::ACT_REM) begin
						status_q <= dfr_pkg::ST_DONE;
					end else if (req.action == dfr_pkg::ACT_DEQ && count_q != '0) begin
						status_q <= dfr_pkg::ST_DONE;
					end else begin
						status_q <= dfr_pkg::ST_ABSENT;
					end
				end
			end
			S_SREAD: begin
				if (idx_q == count_q) begin
					priority if (action_q == dfr_pkg::ACT_REM) begin
						status_q <= dfr_pkg::ST_ABSENT;
					end else if (!enq_ok) begin
						status_q <= dfr_pkg::ST_FULL;
					end else begin
						status_q <= dfr_pkg::ST_DONE;
					end
				end
			end
			S_SCMP: begin
				if (key_eq && action_q == dfr_pkg::ACT_ENQ) begin
					status_q <= dfr_pkg::ST_DUP;
				end
			end
			S_DCAP: begin
				outv_q  <= 1'b1;
				oitem_q <= 32'(rd_data_q);
			end
			S_HCAP: begin
				head_q <= (count_q != '0) ? 32'(rd_data_q) : '0;
			end
			S_DONE: begin
				if (!rsp_full_q || rsp_acc) begin
					rsp_q.status     <= status_q;
					rsp_q.out_valid  <= outv_q;
					rsp_q.out_item   <= oitem_q;
					rsp_q.head_valid <= (count_q != '0);
					rsp_q.head_item  <= head_q;
					rsp_q.occupancy  <= 5'(count_q);
				end
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

	`include "dedup_fifo_with_removal_unit_assert.svh"

	`DFR_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "count beyond depth")
	`DFR_ASSERT_NEXT(a_count_step, 1'b1, (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)), "count moved by more than one")
	`DFR_ASSERT_NEXT(a_rsp_source, (state_q != S_DONE) && !rsp_valid, !rsp_valid, "response appeared outside done step")
	`DFR_ASSERT_IMPL(a_deq_status, rsp_valid && rsp.out_valid, rsp.status == dfr_pkg::ST_DONE && rsp.head_valid == (rsp.occupancy != 5'd0), "dequeue result inconsistent")
	`DFR_ASSERT_NEXT(a_busy_after_accept, req_acc, state_q != S_IDLE, "sequencer idle after accept")

endmodule
